// ===== design/postfix_stack_evaluator_unit_macros.svh =====
// Assertion macros for the postfix stack evaluator.
// Used by postfix_stack_evaluator_unit; no other dependencies.
`ifndef POSTFIX_STACK_EVALUATOR_UNIT_MACROS_SVH
`define POSTFIX_STACK_EVALUATOR_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define PSE_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define PSE_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define PSE_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define PSE_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ===== design/pse_pkg.sv =====
// Shared types and constants for the postfix stack evaluator.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package pse_pkg;
  localparam int STACK_DEPTH = 16;
  localparam int VAR_SLOTS = 16;
  localparam int MAX_ROWS = 1024;
  localparam int SP_W = $clog2(STACK_DEPTH + 1);
  localparam int VS_W = (VAR_SLOTS > 1) ? $clog2(VAR_SLOTS) : 1;

  localparam logic [2:0] CMD_NUM = 3'd0;
  localparam logic [2:0] CMD_VAR = 3'd1;
  localparam logic [2:0] CMD_OP = 3'd2;
  localparam logic [2:0] CMD_JMP = 3'd3;
  localparam logic [2:0] CMD_END = 3'd4;

  localparam logic [4:0] OP_ASSIGN = 5'd0;
  localparam logic [4:0] OP_LOR = 5'd1;
  localparam logic [4:0] OP_LAND = 5'd2;
  localparam logic [4:0] OP_BOR = 5'd3;
  localparam logic [4:0] OP_XOR = 5'd4;
  localparam logic [4:0] OP_BAND = 5'd5;
  localparam logic [4:0] OP_EQ = 5'd6;
  localparam logic [4:0] OP_NE = 5'd7;
  localparam logic [4:0] OP_LE = 5'd8;
  localparam logic [4:0] OP_LT = 5'd9;
  localparam logic [4:0] OP_GE = 5'd10;
  localparam logic [4:0] OP_GT = 5'd11;
  localparam logic [4:0] OP_SHL = 5'd12;
  localparam logic [4:0] OP_SHR = 5'd13;
  localparam logic [4:0] OP_ADD = 5'd14;
  localparam logic [4:0] OP_SUB = 5'd15;
  localparam logic [4:0] OP_MUL = 5'd16;
  localparam logic [4:0] OP_DIV = 5'd17;

  localparam logic [1:0] FLT_NONE = 2'd0;
  localparam logic [1:0] FLT_UNDER = 2'd1;
  localparam logic [1:0] FLT_OVER = 2'd2;
  localparam logic [1:0] FLT_DIV0 = 2'd3;

  typedef struct packed {
    logic [31:0] value;
    logic        is_var;
  } entry_t;

  // stack shift control shared by all cells
  typedef enum logic [1:0] {SH_HOLD, SH_PUSH, SH_POP1, SH_POP2} shift_t;

  typedef struct packed {
    shift_t      shift;
    logic        clear;
    entry_t      top_in;
  } stack_ctl_t;
endpackage
`default_nettype wire

// ===== design/postfix_stack_evaluator_unit.sv =====
// Top level of the postfix stack evaluator: control, ALU, variable file, cell row.
// Depends on pse_pkg, pse_cell, pse_divider and the macros header.
//
//  channel | signals                                            | dir
//  in      | in_valid/in_ready, command..current_row             | sink
//  out     | out_valid/out_ready, next_row, answer, answer_valid, fault | source
//
// A token is first registered from the request, then computed and shifted into
// the cell row.
// Divide and modulo wait in S_DIV for the bit-serial divider.
// A result waits in the output register; the next token is taken in the cycle it leaves.
// Reset clears the stack, variable file, flags and output valid flag.
`timescale 1ns / 1ps
`default_nettype none
`include "postfix_stack_evaluator_unit_macros.svh"
module postfix_stack_evaluator_unit (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [2:0]         command,
  input  wire logic signed [31:0] number,
  input  wire logic [3:0]         var_slot,
  input  wire logic [4:0]         op,
  input  wire logic               mod_select,
  input  wire logic               conditional,
  input  wire logic [9:0]         target_row,
  input  wire logic [9:0]         current_row,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [10:0]             next_row,
  output logic signed [31:0]      answer,
  output logic                    answer_valid,
  output logic [1:0]              fault
);
  localparam int D = pse_pkg::STACK_DEPTH;

  typedef enum logic [1:0] {S_IDLE, S_EXEC, S_DIV} state_t;
  state_t state;

  logic [2:0]  r_cmd;
  logic [31:0] r_num;
  logic [3:0]  r_slot;
  logic [4:0]  r_op;
  logic        r_mod, r_cond;
  logic [9:0]  r_tgt, r_cur;

  logic [pse_pkg::SP_W-1:0] sp;
  logic [31:0] vars [pse_pkg::VAR_SLOTS];
  logic [31:0] last_value;
  logic        have_last, skipping;
  logic [1:0]  line_fault;

  pse_pkg::entry_t   cell_data [D];
  logic              cell_full [D];
  pse_pkg::stack_ctl_t ctl;

  for (genvar g = 0; g < D; g++) begin : g_cell
    pse_pkg::entry_t fa, fa2, fb;
    logic ffa, ffa2, ffb;
    always_comb begin
      fa = (g > 0) ? cell_data[(g > 0) ? g - 1 : 0] : '0;
      ffa = (g > 0) ? cell_full[(g > 0) ? g - 1 : 0] : 1'b0;
      fa2 = (g < D - 1) ? cell_data[(g < D - 1) ? g + 1 : g] : '0;
      ffa2 = (g < D - 1) ? cell_full[(g < D - 1) ? g + 1 : g] : 1'b0;
      fb = (g < D - 1) ? cell_data[(g < D - 1) ? g + 1 : g] : '0;
      ffb = (g < D - 1) ? cell_full[(g < D - 1) ? g + 1 : g] : 1'b0;
      if (g > 0) begin
        fa2 = (g < D - 1) ? cell_data[(g < D - 1) ? g + 1 : g] : '0;
      end
    end
    pse_cell u_cell (
      .clk(clk), .rst(rst), .ctl(ctl),
      .from_above(fa), .from_above2(fa2), .from_below(fb),
      .above_full(ffa), .above2_full(ffa2), .below_full(ffb),
      .is_top(g == 0), .data(cell_data[g]), .full(cell_full[g])
    );
  end

  // operand read
  function automatic logic [31:0] rd(input pse_pkg::entry_t e,
                                     input logic [31:0] v [pse_pkg::VAR_SLOTS]);
    logic [31:0] r;
    r = e.value;
    if (e.is_var) begin
      r = (e.value < 32'(pse_pkg::VAR_SLOTS)) ? v[e.value[pse_pkg::VS_W-1:0]] : 32'd0;
    end
    return r;
  endfunction

  logic [31:0] rv, lv;
  assign rv = rd(cell_data[0], vars);
  assign lv = rd(cell_data[1], vars);

  logic lt_lr, lt_rl;
  assign lt_lr = $signed(lv) < $signed(rv);
  assign lt_rl = $signed(rv) < $signed(lv);

  logic [31:0] alu;
  always_comb begin
    case (r_op)
      pse_pkg::OP_ASSIGN: alu = rv;
      pse_pkg::OP_LOR:  alu = {31'd0, (lv != 0) || (rv != 0)};
      pse_pkg::OP_LAND: alu = {31'd0, (lv != 0) && (rv != 0)};
      pse_pkg::OP_BOR:  alu = lv | rv;
      pse_pkg::OP_XOR:  alu = lv ^ rv;
      pse_pkg::OP_BAND: alu = lv & rv;
      pse_pkg::OP_EQ:   alu = {31'd0, lv == rv};
      pse_pkg::OP_NE:   alu = {31'd0, lv != rv};
      pse_pkg::OP_LE:   alu = {31'd0, !lt_rl};
      pse_pkg::OP_LT:   alu = {31'd0, lt_lr};
      pse_pkg::OP_GE:   alu = {31'd0, !lt_lr};
      pse_pkg::OP_GT:   alu = {31'd0, lt_rl};
      pse_pkg::OP_SHL:  alu = lv << rv[4:0];
      pse_pkg::OP_SHR:  alu = 32'($signed(lv) >>> rv[4:0]);
      pse_pkg::OP_ADD:  alu = lv + rv;
      pse_pkg::OP_SUB:  alu = lv - rv;
      pse_pkg::OP_MUL:  alu = 32'(lv * rv);
      default:          alu = '0;
    endcase
  end

  logic        div_start, div_done;
  logic [31:0] q, rem, ua, ub;
  logic        lneg, rneg;
  assign ua = lv[31] ? 32'd0 - lv : lv;
  assign ub = rv[31] ? 32'd0 - rv : rv;
  pse_divider u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(ua), .divisor(ub),
    .done(div_done), .quotient(q), .remainder(rem)
  );

  logic is_div_op, valid_op;
  assign is_div_op = r_mod || (r_op == pse_pkg::OP_DIV);
  assign valid_op = r_mod || (r_op <= pse_pkg::OP_DIV);

  function automatic logic [10:0] clip(input logic [10:0] r);
    return (r >= 11'(pse_pkg::MAX_ROWS)) ? 11'(pse_pkg::MAX_ROWS) : r;
  endfunction

  logic [31:0] res;
  logic        do_shift;
  logic [1:0]  flt_next;

  assign in_ready = (state == S_IDLE) && (!out_valid || out_ready);
  assign div_start = (state == S_EXEC) && r_cmd == pse_pkg::CMD_OP && !skipping
                     && valid_op && is_div_op && sp >= 2 && ub != 0;

  always_comb begin
    ctl = '0;
    ctl.shift = pse_pkg::SH_HOLD;
    res = alu;
    do_shift = 1'b0;
    if (state == S_DIV && div_done) begin
      res = r_mod ? (lneg ? 32'd0 - rem : rem) : ((lneg != rneg) ? 32'd0 - q : q);
      do_shift = 1'b1;
    end else if (state == S_EXEC && !skipping && r_cmd == pse_pkg::CMD_OP && valid_op
                 && sp >= 2 && (!is_div_op || ub == 0)) begin
      res = is_div_op ? 32'd0 : alu;
      do_shift = 1'b1;
    end
    if (do_shift) begin
      ctl.shift = pse_pkg::SH_POP2;
      ctl.top_in = '{value: res, is_var: 1'b0};
    end else if (state == S_EXEC && !skipping && sp < pse_pkg::SP_W'(D)) begin
      if (r_cmd == pse_pkg::CMD_NUM) begin
        ctl.shift = pse_pkg::SH_PUSH;
        ctl.top_in = '{value: r_num, is_var: 1'b0};
      end else if (r_cmd == pse_pkg::CMD_VAR) begin
        ctl.shift = pse_pkg::SH_PUSH;
        ctl.top_in = '{value: {28'd0, r_slot}, is_var: 1'b1};
      end
    end
    if (state == S_EXEC && !skipping && r_cmd == pse_pkg::CMD_JMP && r_cond && sp != 0
        && rv != 0) begin
      ctl.shift = pse_pkg::SH_POP1;
    end
    if (state == S_EXEC && (r_cmd == pse_pkg::CMD_END
        || (!skipping && r_cmd == pse_pkg::CMD_JMP && (!r_cond || (sp != 0 && rv == 0))))) begin
      ctl.clear = 1'b1;
    end
  end

  always_comb begin
    flt_next = line_fault;
    if (line_fault == pse_pkg::FLT_NONE && state == S_EXEC && !skipping) begin
      if ((r_cmd == pse_pkg::CMD_NUM || r_cmd == pse_pkg::CMD_VAR) && sp >= pse_pkg::SP_W'(D))
        flt_next = pse_pkg::FLT_OVER;
      else if (r_cmd == pse_pkg::CMD_OP && valid_op && sp < 2)
        flt_next = pse_pkg::FLT_UNDER;
      else if (r_cmd == pse_pkg::CMD_OP && valid_op && is_div_op && ub == 0)
        flt_next = pse_pkg::FLT_DIV0;
      else if (r_cmd == pse_pkg::CMD_JMP && r_cond && sp == 0)
        flt_next = pse_pkg::FLT_UNDER;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      sp <= '0;
      last_value <= '0;
      have_last <= 1'b0;
      skipping <= 1'b0;
      line_fault <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < pse_pkg::VAR_SLOTS; i++) vars[i] <= '0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      line_fault <= flt_next;
      case (state)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            state <= S_EXEC;
            r_cmd <= command; r_num <= number; r_slot <= var_slot; r_op <= op;
            r_mod <= mod_select; r_cond <= conditional;
            r_tgt <= target_row; r_cur <= current_row;
          end
        end
        S_EXEC: begin
          state <= S_IDLE;
          lneg <= lv[31];
          rneg <= rv[31];
          if (div_start) state <= S_DIV;
          if (ctl.shift == pse_pkg::SH_PUSH) sp <= sp + 1'b1;
          if (ctl.shift == pse_pkg::SH_POP1) sp <= sp - 1'b1;
          if (do_shift) begin
            sp <= sp - 1'b1;
            last_value <= res;
            have_last <= 1'b1;
            if (!r_mod && r_op == pse_pkg::OP_ASSIGN && cell_data[1].is_var
                && cell_data[1].value < 32'(pse_pkg::VAR_SLOTS))
              vars[cell_data[1].value[pse_pkg::VS_W-1:0]] <= rv;
          end
          if (r_cmd == pse_pkg::CMD_END) begin
            skipping <= 1'b0;
            if (!skipping) begin
              out_valid <= 1'b1;
              next_row <= clip({1'b0, r_cur} + 11'd1);
              fault <= line_fault;
              if (sp != 0) begin
                answer <= rv; answer_valid <= 1'b1;
              end else begin
                answer <= have_last ? last_value : 32'd0; answer_valid <= have_last;
              end
            end
          end
          if (ctl.clear) begin
            sp <= '0; last_value <= '0; have_last <= 1'b0; line_fault <= '0;
          end
          if (ctl.clear && r_cmd == pse_pkg::CMD_JMP) begin
            skipping <= 1'b1;
            out_valid <= 1'b1;
            next_row <= clip({1'b0, r_tgt});
            fault <= flt_next;
            answer <= have_last ? last_value : 32'd0;
            answer_valid <= have_last;
          end
        end
        S_DIV: begin
          if (div_done) begin
            state <= S_IDLE;
            sp <= sp - 1'b1;
            last_value <= res;
            have_last <= 1'b1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `PSE_ASSERT_IMP(a_sp_range, clk, rst, 1'b1, sp <= pse_pkg::SP_W'(D))
  `PSE_ASSERT_IMP(a_no_accept_busy, clk, rst, state != S_IDLE, !in_ready)
  `PSE_ASSERT_NEXT(a_div_enter, clk, rst, div_start, state == S_DIV)
  `PSE_ASSERT_IMP(a_no_shift_idle, clk, rst, state == S_IDLE, ctl.shift == pse_pkg::SH_HOLD)
endmodule
`default_nettype wire

// ===== design/pse_cell.sv =====
// One stack cell: holds an entry and shifts with its neighbours.
// Depends on pse_pkg.
`timescale 1ns / 1ps
`default_nettype none
module pse_cell (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire pse_pkg::stack_ctl_t ctl,
  input  wire pse_pkg::entry_t    from_above,
  input  wire pse_pkg::entry_t    from_above2,
  input  wire pse_pkg::entry_t    from_below,
  input  wire logic               above_full,
  input  wire logic               above2_full,
  input  wire logic               below_full,
  input  wire logic               is_top,
  output pse_pkg::entry_t         data,
  output logic                    full
);
  // cell 0 is the top of stack; deeper cells follow
  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      full <= 1'b0;
    end else begin
      case (ctl.shift)
        pse_pkg::SH_PUSH: begin
          full <= is_top ? 1'b1 : above_full;
          data <= is_top ? ctl.top_in : from_above;
        end
        pse_pkg::SH_POP1: begin
          full <= below_full;
          data <= from_below;
        end
        pse_pkg::SH_POP2: begin
          full <= is_top ? above2_full : above2_full;
          data <= is_top ? ctl.top_in : from_above2;
        end
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== design/pse_divider.sv =====
// Radix-2 unsigned divider, one quotient bit per cycle.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module pse_divider (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [31:0] dividend,
  input  wire logic [31:0] divisor,
  output logic             done,
  output logic [31:0]      quotient,
  output logic [31:0]      remainder
);
  logic [5:0]  count;
  logic        busy;
  logic [32:0] trial;
  assign trial = {remainder, quotient[31]} - {1'b0, divisor};
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        count <= 6'd32;
        quotient <= dividend;
        remainder <= '0;
      end else if (busy) begin
        if (trial[32]) begin
          remainder <= {remainder[30:0], quotient[31]};
          quotient <= {quotient[30:0], 1'b0};
        end else begin
          remainder <= trial[31:0];
          quotient <= {quotient[30:0], 1'b1};
        end
        count <= count - 6'd1;
        if (count == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

// ===== tb/postfix_stack_evaluator_unit_checker.sv =====
// Checker for the postfix stack evaluator: watches the token and result channels,
// predicts each result from accepted tokens and compares. Depends on pse_pkg.
`timescale 1ns / 1ps
module postfix_stack_evaluator_unit_checker
  import pse_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [2:0]         command,
  input  logic signed [31:0] number,
  input  logic [3:0]         var_slot,
  input  logic [4:0]         op,
  input  logic               mod_select,
  input  logic               conditional,
  input  logic [9:0]         target_row,
  input  logic [9:0]         current_row,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [10:0]        next_row,
  input  logic signed [31:0] answer,
  input  logic               answer_valid,
  input  logic [1:0]         fault,
  output int                 failures,
  output int                 pending
);
  typedef struct packed {
    logic [10:0] row;
    logic [31:0] ans;
    logic        ans_ok;
    logic [1:0]  flt;
  } line_result_t;

  line_result_t result_q[$];
  logic [31:0] stk_val[STACK_DEPTH];
  logic        stk_var[STACK_DEPTH];
  int          sp;
  logic [31:0] vars[VAR_SLOTS];
  logic [31:0] last_v;
  logic        have_last, skipping;
  logic [1:0]  line_flt;

  assign pending = result_q.size();

  function automatic logic [31:0] entry_value(int idx);
    if (stk_var[idx]) return (stk_val[idx] < VAR_SLOTS) ? vars[stk_val[idx]] : 32'd0;
    return stk_val[idx];
  endfunction

  task automatic flag(logic [1:0] c);
    if (line_flt == FLT_NONE) line_flt = c;
  endtask

  task automatic push(logic [31:0] v, logic isv);
    if (sp >= STACK_DEPTH) flag(FLT_OVER);
    else begin
      stk_val[sp] = v;
      stk_var[sp] = isv;
      sp++;
    end
  endtask

  task automatic clear_line();
    sp = 0;
    last_v = 0;
    have_last = 0;
    line_flt = FLT_NONE;
  endtask

  task automatic post(logic [10:0] row, logic ok, logic [31:0] a);
    line_result_t r;
    r.row = (row >= MAX_ROWS) ? 11'(MAX_ROWS) : row;
    r.ans = ok ? a : 32'd0;
    r.ans_ok = ok;
    r.flt = line_flt;
    result_q = {result_q, r};
  endtask

  function automatic logic [31:0] divide(logic [31:0] l, logic [31:0] r, logic want_mod,
                                         output logic dz);
    logic [31:0] ua, ub, q;
    ua = l[31] ? -l : l;
    ub = r[31] ? -r : r;
    dz = (ub == 0);
    if (dz) return 0;
    if (want_mod) begin
      q = ua % ub;
      return l[31] ? -q : q;
    end
    q = ua / ub;
    return (l[31] != r[31]) ? -q : q;
  endfunction

  task automatic evaluate_token();
    logic [31:0] l, r, v;
    logic dz, taken;
    int li;
    dz = 0;
    if (command == CMD_END) begin
      if (skipping) skipping = 0;
      else if (sp > 0) post(11'(current_row) + 1, 1, entry_value(sp - 1));
      else post(11'(current_row) + 1, have_last, last_v);
      clear_line();
      return;
    end
    if (skipping || command > CMD_END) return;
    case (command)
      CMD_NUM: push(number, 0);
      CMD_VAR: push(32'(var_slot), 1);
      CMD_OP: begin
        if (!mod_select && op > OP_DIV) return;
        if (sp < 2) begin
          flag(FLT_UNDER);
          return;
        end
        li = sp - 2;
        r = entry_value(sp - 1);
        l = entry_value(li);
        if (mod_select) v = divide(l, r, 1, dz);
        else case (op)
          OP_ASSIGN: begin
            v = r;
            if (stk_var[li] && stk_val[li] < VAR_SLOTS) vars[stk_val[li]] = v;
          end
          OP_LOR:  v = (l != 0 || r != 0);
          OP_LAND: v = (l != 0 && r != 0);
          OP_BOR:  v = l | r;
          OP_XOR:  v = l ^ r;
          OP_BAND: v = l & r;
          OP_EQ:   v = (l == r);
          OP_NE:   v = (l != r);
          OP_LE:   v = ($signed(l) <= $signed(r));
          OP_LT:   v = ($signed(l) < $signed(r));
          OP_GE:   v = ($signed(l) >= $signed(r));
          OP_GT:   v = ($signed(l) > $signed(r));
          OP_SHL:  v = l << r[4:0];
          OP_SHR:  v = $signed(l) >>> r[4:0];
          OP_ADD:  v = l + r;
          OP_SUB:  v = l - r;
          OP_MUL:  v = l * r;
          default: v = divide(l, r, 0, dz);
        endcase
        if (dz) flag(FLT_DIV0);
        sp = li;
        push(v, 0);
        last_v = v;
        have_last = 1;
      end
      default: begin
        taken = 1;
        if (conditional) begin
          if (sp == 0) begin
            flag(FLT_UNDER);
            taken = 0;
          end else begin
            sp--;
            taken = (entry_value(sp) == 0);
          end
        end
        if (taken) begin
          post(11'(target_row), have_last, last_v);
          clear_line();
          skipping = 1;
        end
      end
    endcase
  endtask

  always @(posedge clk) begin
    line_result_t e;
    if (rst) begin
      result_q.delete();
      failures <= 0;
      clear_line();
      skipping = 0;
      for (int k = 0; k < VAR_SLOTS; k++) vars[k] = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (result_q.size() == 0) begin
          $error("result with none expected");
          failures <= failures + 1;
        end else begin
          e = result_q.pop_front();
          if (next_row !== e.row || answer !== e.ans || answer_valid !== e.ans_ok ||
              fault !== e.flt) begin
            if (next_row !== e.row) $error("next_row exp %0d got %0d", e.row, next_row);
            if (answer !== e.ans) $error("answer exp %h got %h", e.ans, answer);
            if (answer_valid !== e.ans_ok)
              $error("answer_valid exp %0d got %0d", e.ans_ok, answer_valid);
            if (fault !== e.flt) $error("fault exp %0d got %0d", e.flt, fault);
            failures <= failures + 1;
          end
        end
      end
      if (in_valid && in_ready) evaluate_token();
    end
  end
endmodule

// ===== tb/postfix_stack_evaluator_unit_tb.sv =====
// Testbench top for the postfix stack evaluator: drives token requests and
// result back-pressure, gives the verdict. Depends on pse_pkg, the unit and the checker.
`timescale 1ns / 1ps
module postfix_stack_evaluator_unit_tb;
  import pse_pkg::*;
  logic clk = 0, rst = 1;
  logic in_valid = 0, in_ready, out_valid, out_ready = 0;
  logic [2:0] command = 0;
  logic signed [31:0] number = 0;
  logic [3:0] var_slot = 0;
  logic [4:0] op = 0;
  logic mod_select = 0, conditional = 0;
  logic [9:0] target_row = 0, current_row = 0;
  logic [10:0] next_row;
  logic signed [31:0] answer;
  logic answer_valid;
  logic [1:0] fault;
  int failures, pending;
  int send_idle = 0, recv_stall = 0;
  bit hold_off = 0;

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  postfix_stack_evaluator_unit uut (.*);
  postfix_stack_evaluator_unit_checker chk (.*);

  always @(negedge clk) begin
    if (hold_off) out_ready <= 0;
    else out_ready <= ($urandom_range(99) >= recv_stall);
  end

  // valid stays high between back-to-back requests; it drops only while idling
  task automatic send(logic [2:0] c, logic [31:0] n = 0, logic [3:0] s = 0,
                      logic [4:0] o = 0, logic m = 0, logic cd = 0,
                      logic [9:0] tr = 0, logic [9:0] cr = 0);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 0;
      @(negedge clk);
    end
    command <= c; number <= n; var_slot <= s; op <= o;
    mod_select <= m; conditional <= cd; target_row <= tr; current_row <= cr;
    in_valid <= 1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [31:0] rand_num();
    case ($urandom_range(5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      3: return $urandom_range(3);
      default: return $urandom;
    endcase
  endfunction

  task automatic rand_token(int cmd_max);
    logic [2:0] c;
    c = 3'($urandom_range(cmd_max));
    send(c, rand_num(), 4'($urandom),
         5'($urandom_range(9) == 0 ? $urandom : $urandom_range(17)),
         $urandom_range(7) == 0, 1'($urandom), 10'($urandom), 10'($urandom));
  endtask

  // mostly well-formed lines with random content
  task automatic rand_line();
    int n;
    logic [9:0] row;
    row = 10'($urandom);
    n = $urandom_range(1, 6);
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(9) < 6) send($urandom_range(1) ? CMD_NUM : CMD_VAR, rand_num(),
                                      4'($urandom));
      if (k > 0 || $urandom_range(4) == 0)
        send(CMD_OP, 0, 0, 5'($urandom_range(17)), $urandom_range(9) == 0);
      if ($urandom_range(15) == 0) rand_token(7);
      if ($urandom_range(19) == 0)
        send(CMD_JMP, 0, 0, 0, 0, 1'($urandom), 10'($urandom), row);
    end
    send(CMD_END, 0, 0, 0, 0, 0, 0, row);
  endtask

  initial begin
    #5_000_000;
    $display("postfix_stack_evaluator_unit verification failed");
    $finish;
  end

  initial begin
    int idle_tab[4] = '{0, 62, 0, 18};
    int stall_tab[4] = '{0, 0, 62, 18};
    repeat (6) @(posedge clk);
    @(negedge clk) rst <= 0;
    // directed
    send(CMD_END, 0, 0, 0, 0, 0, 0, 10'd1023);
    send(CMD_VAR, 0, 4'd15); send(CMD_NUM, 32'h8000_0000); send(CMD_OP, 0, 0, OP_ASSIGN);
    send(CMD_NUM, 32'h8000_0000); send(CMD_NUM, 32'hffff_ffff); send(CMD_OP, 0, 0, OP_DIV);
    send(CMD_NUM, 5); send(CMD_NUM, 0); send(CMD_OP, 0, 0, 0, 1);
    send(CMD_NUM, 7); send(CMD_NUM, 1); send(CMD_OP, 0, 0, OP_ASSIGN);
    send(CMD_VAR, 0, 4'd15); send(CMD_NUM, 32'hffff_ffe1); send(CMD_OP, 0, 0, OP_SHR);
    send(CMD_OP, 0, 0, 5'd31); send(3'd7);
    send(CMD_END, 0, 0, 0, 0, 0, 0, 10'd5);
    send(CMD_OP); send(CMD_JMP, 0, 0, 0, 0, 1, 10'd3);
    send(CMD_JMP, 0, 0, 0, 0, 0, 10'd1023); send(CMD_NUM, 1);
    send(CMD_END, 0, 0, 0, 0, 0, 0, 10'd9);
    for (int k = 0; k < 17; k++) send(CMD_NUM, k);
    send(CMD_END, 0, 0, 0, 0, 0, 0, 10'd0);
    for (int ph = 0; ph < 4; ph++) begin
      send_idle = idle_tab[ph];
      recv_stall = stall_tab[ph];
      for (int t = 0; t < 38; t++) rand_line();
      if (ph == 2) begin
        fork
          begin
            hold_off = 1;
            repeat (300) @(negedge clk);
            hold_off = 0;
          end
          for (int t = 0; t < 10; t++) rand_line();
        join
      end
    end
    in_valid <= 0;
    send_idle = 0;
    recv_stall = 0;
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (failures == 0) $display("postfix_stack_evaluator_unit verification clean");
    else $display("postfix_stack_evaluator_unit verification failed");
    $finish;
  end
endmodule
